>>> hdl/ichk_pkg.sv
// Package for the streaming internet checksum block.
// Holds the input item type, packet kind codes, protocol constants and the fold adder.
// No dependencies.
package ichk_pkg;

  localparam logic [1:0] KIND_IP  = 2'd0;
  localparam logic [1:0] KIND_UDP = 2'd1;
  localparam logic [1:0] KIND_TCP = 2'd2;

  localparam logic [15:0] PROTO_UDP  = 16'd17;
  localparam logic [15:0] PROTO_TCP  = 16'd6;
  localparam logic [15:0] ADDR_BYTES = 16'd8;
  localparam logic [15:0] WORD_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] kind;
  } item_t;

  // Ones' complement add of two 16-bit words with end-around carry.
  // A single fold is enough because the folded result cannot carry again.
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

>>> hdl/ichk_in_reg.sv
// Input register stage of the internet checksum block.
// Captures one byte transfer and holds it until the core takes it; uses ichk_pkg.
module ichk_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [1:0]           packet_kind,
  output logic                 item_valid,
  output ichk_pkg::item_t      item,
  input  logic                 take
);
  import ichk_pkg::*;

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data <= data_byte;
      item.last <= last_byte;
      item.kind <= packet_kind;
    end
  end

endmodule

>>> hdl/ichk_core.sv
// Checksum core: packet state, per-byte fold add, pseudo-header terms and result register.
// Consumes items from ichk_in_reg; uses ichk_pkg.
module ichk_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  ichk_pkg::item_t      item,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          checksum_value,
  output logic                 too_long
);
  import ichk_pkg::*;

  logic [15:0] running_sum;
  logic [7:0]  pending_high_byte;
  logic        odd_position;
  logic [15:0] byte_count;
  logic        count_overflow;

  logic [15:0] sum_next;
  logic [15:0] count_next;
  logic        overflow_next;
  logic [15:0] len_term;
  logic [15:0] proto_term;
  logic [15:0] final_sum;
  logic        pseudo;

  assign take = item_valid && (!item.last || !out_valid || out_ready);

  always_comb begin
    count_next    = byte_count + 16'd1;
    overflow_next = count_overflow || (byte_count == WORD_MAX);
    if (odd_position) begin
      sum_next = fold_add(running_sum, {pending_high_byte, item.data});
    end else if (item.last) begin
      sum_next = fold_add(running_sum, {item.data, 8'h00});
    end else begin
      sum_next = running_sum;
    end
    len_term = count_next - ADDR_BYTES;
    case (item.kind)
      KIND_UDP: begin
        proto_term = PROTO_UDP;
        pseudo     = 1'b1;
      end
      KIND_TCP: begin
        proto_term = PROTO_TCP;
        pseudo     = 1'b1;
      end
      default: begin
        proto_term = 16'd0;
        pseudo     = 1'b0;
      end
    endcase
    if (pseudo) begin
      final_sum = fold_add(fold_add(sum_next, proto_term), len_term);
    end else begin
      final_sum = sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum       <= 16'd0;
      pending_high_byte <= 8'd0;
      odd_position      <= 1'b0;
      byte_count        <= 16'd0;
      count_overflow    <= 1'b0;
    end else if (take) begin
      if (item.last) begin
        running_sum       <= 16'd0;
        pending_high_byte <= 8'd0;
        odd_position      <= 1'b0;
        byte_count        <= 16'd0;
        count_overflow    <= 1'b0;
      end else begin
        running_sum    <= sum_next;
        byte_count     <= count_next;
        count_overflow <= overflow_next;
        if (odd_position) begin
          odd_position      <= 1'b0;
          pending_high_byte <= 8'd0;
        end else begin
          odd_position      <= 1'b1;
          pending_high_byte <= item.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last) begin
      checksum_value <= ~final_sum;
      too_long       <= overflow_next;
    end
  end

endmodule

>>> hdl/internet_checksum_pseudo_header.sv
// Top level of the streaming internet checksum with UDP/TCP pseudo-header terms.
// Instantiates ichk_in_reg and ichk_core; uses ichk_pkg.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid / in_ready | data_byte, last_byte, packet_kind
//   output  | out_valid/out_ready | checksum_value, too_long
//
// One byte is accepted per cycle while in_ready is high. The last byte goes through the input
// register, then the result register. The input register and the result register each hold one
// transfer, so input keeps flowing while a result waits, until a second last byte meets a full
// result register. Synchronous reset clears the packet state and both valid flags.
module internet_checksum_pseudo_header (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [1:0]  packet_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] checksum_value,
  output logic        too_long
);
  import ichk_pkg::*;

  logic  item_valid;
  item_t item;
  logic  take;

  ichk_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .packet_kind (packet_kind),
    .item_valid  (item_valid),
    .item        (item),
    .take        (take)
  );

  ichk_core u_core (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item           (item),
    .take           (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .checksum_value (checksum_value),
    .too_long       (too_long)
  );

endmodule
